// ----- rtl/btrm_pkg.sv -----
// ----------------------------------------------------------------------------
// btrm_pkg
// Shared constants, codes and types of the battery temperature rise monitor.
// ----------------------------------------------------------------------------
package btrm_pkg;

	localparam int MODULES  = 8;
	localparam int SENS_CNT = MODULES + 1;
	localparam int SIDX_W   = $clog2(SENS_CNT);
	localparam int MIDX_W   = 3;

	localparam logic [SIDX_W-1:0] AMB_IDX = SIDX_W'(MODULES);

	localparam logic [7:0]  TEMP_INVALID = 8'd99;
	localparam logic [3:0]  CNT_MAX      = 4'd15;
	localparam logic [11:0] READ_MAX     = 12'd1584;

	localparam logic [1:0] FUNC_CHECK   = 2'd0;
	localparam logic [1:0] FUNC_CAPTURE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [1:0] FUNC_AMBIENT = 2'd3;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_MAX_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMB_MODE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_OFFSETS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AMB_OFFSET   = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ----- rtl/battery_temp_rise_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// battery_temp_rise_monitor_unit
// Per-sensor temperature sampling, peak tracking and rise grading.
// ----------------------------------------------------------------------------
// Sequence: an accepted request is registered, the update step runs in ST_EXEC
//   and the result is held in ST_HOLD until it is accepted. One request at a
//   time: the next is taken the cycle after the result is accepted.
// Reset: all sensor stores, counters and config registers return to their
//   defaults at once; no clearing pass.
module battery_temp_rise_monitor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     func,
	input  logic [btrm_pkg::MIDX_W-1:0]    sensor_index,
	input  logic signed [11:0]             reading_sixteenths,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     alert_level,
	output logic                           sampled,
	output logic [7:0]                     current_temp,
	output logic [7:0]                     initial_temp,
	output logic [7:0]                     highest_temp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [btrm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import btrm_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	btrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	btrm_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.func               (func),
		.sensor_index       (sensor_index),
		.reading_sixteenths (reading_sixteenths),
		.alert_level        (alert_level),
		.sampled            (sampled),
		.current_temp       (current_temp),
		.initial_temp       (initial_temp),
		.highest_temp       (highest_temp)
	);

endmodule

// ----- rtl/btrm_ctrl.sv -----
// ----------------------------------------------------------------------------
// btrm_ctrl
// Sequencer: takes a request, runs the update step, holds the result.
// ----------------------------------------------------------------------------
module btrm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output btrm_pkg::dp_cmd_t cmd
);
	import btrm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_HOLD;
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/btrm_dp.sv -----
// ----------------------------------------------------------------------------
// btrm_dp
// Datapath: config registers, per-sensor stores, sampling and grading.
// ----------------------------------------------------------------------------
module btrm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  btrm_pkg::dp_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [btrm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic [1:0]                       func,
	input  logic [btrm_pkg::MIDX_W-1:0]      sensor_index,
	input  logic signed [11:0]               reading_sixteenths,
	output logic [1:0]                       alert_level,
	output logic                             sampled,
	output logic [7:0]                       current_temp,
	output logic [7:0]                       initial_temp,
	output logic [7:0]                       highest_temp
);
	import btrm_pkg::*;

	// config
	logic [7:0]  rise_thr_q;
	logic [7:0]  rise_max_thr_q;
	logic        amb_mode_q;
	logic [63:0] mod_off_q;
	logic [7:0]  amb_off_q;

	// state
	logic [3:0] cnt_q  [SENS_CNT];
	logic [7:0] cur_q  [SENS_CNT];
	logic [7:0] init_q [MODULES];
	logic [7:0] high_q [MODULES];

	// captured request
	logic [1:0]        func_q;
	logic [MIDX_W-1:0] idx_q;
	logic [11:0]       raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_thr_q     <= 8'd7;
			rise_max_thr_q <= 8'd10;
			amb_mode_q     <= 1'b0;
			mod_off_q      <= '0;
			amb_off_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RISE_THR:     rise_thr_q     <= cfg_data[7:0];
				CFG_RISE_MAX_THR: rise_max_thr_q <= cfg_data[7:0];
				CFG_AMB_MODE:     amb_mode_q     <= cfg_data[0];
				CFG_MOD_OFFSETS:  mod_off_q      <= cfg_data;
				CFG_AMB_OFFSET:   amb_off_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			idx_q  <= sensor_index;
			raw_q  <= reading_sixteenths;
		end
	end

	logic              idx_ok;
	logic              is_amb;
	logic              touch;
	logic [SIDX_W-1:0] sel;
	logic [3:0]        cnt_old;
	logic [7:0]        cur_old;
	logic [7:0]        init_old;
	logic [7:0]        high_old;
	logic [7:0]        off;
	logic              take;
	logic [7:0]        whole;
	logic [7:0]        cur_new;
	logic [7:0]        high_new;
	logic [7:0]        ref_t;
	logic signed [9:0] rise;
	logic [1:0]        level;

	always_comb begin
		idx_ok   = ({1'b0, idx_q} < (MIDX_W + 1)'(MODULES));
		is_amb   = (func_q == FUNC_AMBIENT);
		touch    = is_amb || (idx_ok && (func_q == FUNC_CHECK || func_q == FUNC_CAPTURE));
		sel      = is_amb ? AMB_IDX : SIDX_W'(idx_q);
		cnt_old  = cnt_q[sel];
		cur_old  = cur_q[sel];
		init_old = init_q[idx_q];
		high_old = high_q[idx_q];
		off      = is_amb ? amb_off_q : mod_off_q[{idx_q, 3'b000} +: 8];
		take     = (cnt_old == CNT_MAX) || (cur_old == 8'd0) || (cur_old == TEMP_INVALID)
			|| (func_q == FUNC_CAPTURE);
		if (raw_q[11] || raw_q > READ_MAX) begin
			whole = cur_old;
		end else begin
			whole = {1'b0, raw_q[10:4]};
		end
		cur_new  = (touch && take) ? (whole + off) : cur_old;
		high_new = (cur_new > high_old && cur_new != TEMP_INVALID) ? cur_new : high_old;
		ref_t    = amb_mode_q ? cur_q[AMB_IDX] : init_old;
		rise     = $signed({2'b00, cur_new}) - $signed({2'b00, ref_t});
		level    = 2'd0;
		if (rise > $signed({2'b00, rise_thr_q}) && cur_new != TEMP_INVALID
			&& cur_new != 8'd0) begin
			level = (rise > $signed({2'b00, rise_max_thr_q})) ? 2'd2 : 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENS_CNT; i++) begin
				cnt_q[i] <= '0;
				cur_q[i] <= '0;
			end
			for (int i = 0; i < MODULES; i++) begin
				init_q[i] <= '0;
				high_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (touch) begin
				cnt_q[sel] <= take ? 4'd0 : cnt_old + 4'd1;
				cur_q[sel] <= cur_new;
			end
			if (idx_ok) begin
				case (func_q)
					FUNC_CHECK:   high_q[idx_q] <= high_new;
					FUNC_CAPTURE: init_q[idx_q] <= cur_new;
					FUNC_CLEAR:   high_q[idx_q] <= '0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			alert_level  <= (idx_ok && func_q == FUNC_CHECK) ? level : 2'd0;
			sampled      <= touch && take;
			current_temp <= (is_amb || idx_ok) ? cur_new : 8'd0;
			if (!idx_ok) begin
				initial_temp <= 8'd0;
				highest_temp <= 8'd0;
			end else begin
				initial_temp <= (func_q == FUNC_CAPTURE) ? cur_new : init_old;
				case (func_q)
					FUNC_CHECK: highest_temp <= high_new;
					FUNC_CLEAR: highest_temp <= 8'd0;
					default:    highest_temp <= high_old;
				endcase
			end
		end
	end

endmodule

// ----- dv/battery_temp_rise_monitor_checker.sv -----
// ----------------------------------------------------------------------------
// battery_temp_rise_monitor_checker
// Watches the request, result and register channels of the temperature rise
// monitor. It keeps its own copy of the sensor stores and settings and
// predicts the report for each accepted request. Each accepted report is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module battery_temp_rise_monitor_checker
	import btrm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [MIDX_W-1:0]    sensor_index,
	input  logic [11:0]          reading_sixteenths,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           alert_level,
	input  logic                 sampled,
	input  logic [7:0]           current_temp,
	input  logic [7:0]           initial_temp,
	input  logic [7:0]           highest_temp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output int                   pending,
	output int                   errors
);

	localparam logic [1:0] ALERT_NONE  = 2'd0;
	localparam logic [1:0] ALERT_WARN  = 2'd1;
	localparam logic [1:0] ALERT_ALARM = 2'd2;

	typedef struct packed {
		logic [1:0] level;
		logic       took;
		logic [7:0] cur;
		logic [7:0] init;
		logic [7:0] peak;
	} temp_report_t;

	logic [3:0]  visit_cnt [SENS_CNT];
	logic [7:0]  temp_now  [SENS_CNT];
	logic [7:0]  temp_base [MODULES];
	logic [7:0]  temp_peak [MODULES];
	logic [7:0]  thr_warn;
	logic [7:0]  thr_alarm;
	logic        amb_cmp;
	logic [63:0] mod_offs;
	logic [7:0]  amb_offs;

	temp_report_t expected_reports [$];

	initial begin
		pending = 0;
		errors  = 0;
	end

	task automatic clear_monitor_state();
		int i;
		for (i = 0; i < SENS_CNT; i++) begin
			visit_cnt[i] = '0;
			temp_now[i]  = '0;
		end
		for (i = 0; i < MODULES; i++) begin
			temp_base[i] = '0;
			temp_peak[i] = '0;
		end
		thr_warn  = 8'd7;
		thr_alarm = 8'd10;
		amb_cmp   = 1'b0;
		mod_offs  = '0;
		amb_offs  = '0;
	endtask

	// Visit one sensor; returns 1 when a new reading is stored.
	function automatic bit refresh_sensor(int s, logic [11:0] raw, logic [7:0] offs,
			bit forced);
		logic [7:0] whole;
		if (!(visit_cnt[s] == CNT_MAX || temp_now[s] == 8'd0 ||
				temp_now[s] == TEMP_INVALID || forced)) begin
			visit_cnt[s] = visit_cnt[s] + 4'd1;
			return 1'b0;
		end
		visit_cnt[s] = '0;
		if (raw[11] || raw > READ_MAX)
			whole = temp_now[s];
		else
			whole = raw[11:4];
		temp_now[s] = whole + offs;
		return 1'b1;
	endfunction

	function automatic temp_report_t predict_report(logic [1:0] fn, logic [MIDX_W-1:0] idx,
			logic [11:0] raw);
		temp_report_t r;
		logic [7:0]   offs;
		logic [7:0]   refv;
		logic [7:0]   cur;
		int           rise;
		bit           in_range;
		r        = '0;
		in_range = int'(idx) < MODULES;
		offs     = mod_offs[8*idx +: 8];
		if (fn == FUNC_AMBIENT) begin
			r.took = refresh_sensor(MODULES, raw, amb_offs, 1'b0);
			r.cur  = temp_now[MODULES];
		end else if (in_range) begin
			case (fn)
				FUNC_CHECK: begin
					r.took = refresh_sensor(int'(idx), raw, offs, 1'b0);
					cur    = temp_now[idx];
					if (cur > temp_peak[idx] && cur != TEMP_INVALID)
						temp_peak[idx] = cur;
					refv = amb_cmp ? temp_now[MODULES] : temp_base[idx];
					rise = int'(cur) - int'(refv);
					if (rise > int'(thr_warn) && cur != TEMP_INVALID && cur != 8'd0)
						r.level = (rise > int'(thr_alarm)) ? ALERT_ALARM : ALERT_WARN;
					else
						r.level = ALERT_NONE;
				end
				FUNC_CAPTURE: begin
					r.took         = refresh_sensor(int'(idx), raw, offs, 1'b1);
					temp_base[idx] = temp_now[idx];
				end
				default: begin
					temp_peak[idx] = '0;
				end
			endcase
			r.cur = temp_now[idx];
		end
		if (in_range) begin
			r.init = temp_base[idx];
			r.peak = temp_peak[idx];
		end
		return r;
	endfunction

	task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		case (idx)
			CFG_RISE_THR:     thr_warn  = data[7:0];
			CFG_RISE_MAX_THR: thr_alarm = data[7:0];
			CFG_AMB_MODE:     amb_cmp   = data[0];
			CFG_MOD_OFFSETS:  mod_offs  = data;
			CFG_AMB_OFFSET:   amb_offs  = data[7:0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : watch
		temp_report_t want;
		temp_report_t got;
		if (!arst_n) begin
			clear_monitor_state();
			expected_reports.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				expected_reports.push_back(predict_report(func, sensor_index,
					reading_sixteenths));
			if (out_valid && !out_stall) begin
				got = {alert_level, sampled, current_temp, initial_temp, highest_temp};
				if (expected_reports.size() == 0) begin
					if (errors < 10)
						$display("unexpected report: level %0d sampled %0d cur %0d init %0d high %0d",
							got.level, got.took, got.cur, got.init, got.peak);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					if (want.level !== got.level || want.took !== got.took ||
							want.cur !== got.cur || want.init !== got.init ||
							want.peak !== got.peak) begin
						if (errors < 10)
							$display("report mismatch: exp level %0d sampled %0d cur %0d",
								want.level, want.took, want.cur,
								" init %0d high %0d", want.init, want.peak,
								" / got level %0d sampled %0d cur %0d",
								got.level, got.took, got.cur,
								" init %0d high %0d", got.init, got.peak);
						errors++;
					end
				end
			end
			pending <= expected_reports.size();
		end
	end

endmodule

// ----- dv/battery_temp_rise_monitor_unit_test.sv -----
// ----------------------------------------------------------------------------
// battery_temp_rise_monitor_unit_test
// Drives the temperature rise monitor with directed corner requests and then
// random requests under several register settings, with random gaps on the
// request side and random stalls on the report side. Checking is done by the
// checker module beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module battery_temp_rise_monitor_unit_test;
	import btrm_pkg::*;

	localparam int IDLE_LIMIT  = 500;
	localparam int PHASE_ITEMS = 340;

	logic                 clk                = 1'b0;
	logic                 arst_n             = 1'b0;
	logic                 in_valid           = 1'b0;
	logic                 in_stall;
	logic [1:0]           func               = FUNC_CHECK;
	logic [MIDX_W-1:0]    sensor_index       = '0;
	logic signed [11:0]   reading_sixteenths = '0;
	logic                 out_valid;
	logic                 out_stall          = 1'b0;
	logic [1:0]           alert_level;
	logic                 sampled;
	logic [7:0]           current_temp;
	logic [7:0]           initial_temp;
	logic [7:0]           highest_temp;
	logic                 cfg_valid          = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index          = '0;
	logic [63:0]          cfg_data           = '0;

	int pending;
	int errors;
	int idle_cycles = 0;
	int stall_left  = 0;
	bit no_idle     = 1'b0;

	logic [11:0] corner_reads [6] = '{12'd0, 12'd1584, 12'd1585, 12'hFFF, 12'h800, 12'h7FF};

	always #4 clk = ~clk;

	battery_temp_rise_monitor_unit u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.func               (func),
		.sensor_index       (sensor_index),
		.reading_sixteenths (reading_sixteenths),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.alert_level        (alert_level),
		.sampled            (sampled),
		.current_temp       (current_temp),
		.initial_temp       (initial_temp),
		.highest_temp       (highest_temp),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	battery_temp_rise_monitor_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.func               (func),
		.sensor_index       (sensor_index),
		.reading_sixteenths (reading_sixteenths),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.alert_level        (alert_level),
		.sampled            (sampled),
		.current_temp       (current_temp),
		.initial_temp       (initial_temp),
		.highest_temp       (highest_temp),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.pending            (pending),
		.errors             (errors)
	);

	function automatic int wait_draw();
		return no_idle ? 0 : int'($urandom_range(0, 17));
	endfunction

	always @(posedge clk) begin : report_pace
		int n;
		if (out_valid && !out_stall) begin
			n = wait_draw();
			stall_left <= n;
			out_stall  <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left > 1);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL battery_temp_rise_monitor_unit");
			$finish;
		end
	end

	// Call just after the clock rises; returns just after the request has been accepted.
	task automatic send_request(logic [1:0] fn, logic [MIDX_W-1:0] idx, logic [11:0] raw);
		int gap;
		if ($urandom_range(0, 39) == 0)
			no_idle = ~no_idle;
		gap = wait_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid           <= 1'b1;
		func               <= fn;
		sensor_index       <= idx;
		reading_sixteenths <= raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(logic [7:0] thr, logic [7:0] thr_max, logic amb,
			logic [63:0] offs, logic [7:0] amb_offs);
		repeat (3) @(posedge clk);
		write_reg(CFG_RISE_THR, {56'd0, thr});
		write_reg(CFG_RISE_MAX_THR, {56'd0, thr_max});
		write_reg(CFG_AMB_MODE, {63'd0, amb});
		write_reg(CFG_MOD_OFFSETS, offs);
		write_reg(CFG_AMB_OFFSET, {56'd0, amb_offs});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [11:0] pick_reading();
		case ($urandom_range(0, 9))
			0:       return corner_reads[$urandom_range(0, 5)];
			1, 2:    return 12'($urandom_range(0, 4095));
			default: return 12'($urandom_range(0, 1584));
		endcase
	endfunction

	function automatic logic [1:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return FUNC_CHECK;
		else if (r < 72)
			return FUNC_CAPTURE;
		else if (r < 80)
			return FUNC_CLEAR;
		else
			return FUNC_AMBIENT;
	endfunction

	function automatic logic [63:0] small_offsets();
		logic [63:0] v;
		int i;
		for (i = 0; i < 8; i++)
			v[8*i +: 8] = 8'($urandom_range(0, 16) - 8);
		return v;
	endfunction

	task automatic run_random(int n);
		int i;
		for (i = 0; i < n; i++) begin
			send_request(pick_func(), MIDX_W'($urandom_range(0, 7)), pick_reading());
			if ($urandom_range(0, 63) == 0)
				drain_reports();
		end
		drain_reports();
	endtask

	initial begin : stimulus
		logic [7:0] thr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(FUNC_CHECK,   3'd0, 12'd0);
		send_request(FUNC_CHECK,   3'd0, 12'd400);
		send_request(FUNC_CAPTURE, 3'd0, 12'd320);
		send_request(FUNC_CHECK,   3'd0, 12'd800);
		send_request(FUNC_CHECK,   3'd1, 12'd1584);
		send_request(FUNC_CHECK,   3'd1, 12'd1585);
		send_request(FUNC_CHECK,   3'd1, 12'hFFF);
		send_request(FUNC_CHECK,   3'd1, 12'd1583);
		send_request(FUNC_CHECK,   3'd2, 12'h7FF);
		send_request(FUNC_CHECK,   3'd2, 12'h800);
		send_request(FUNC_AMBIENT, 3'd0, 12'd480);
		send_request(FUNC_AMBIENT, 3'd7, 12'hFFF);
		send_request(FUNC_CLEAR,   3'd0, 12'd0);
		send_request(FUNC_CAPTURE, 3'd4, 12'h800);
		send_request(FUNC_CHECK,   3'd4, 12'd192);
		send_request(FUNC_CAPTURE, 3'd5, 12'd0);
		send_request(FUNC_CHECK,   3'd5, 12'd144);
		send_request(FUNC_CHECK,   3'd7, 12'd1584);
		drain_reports();

		run_random(PHASE_ITEMS);

		program_regs(8'd0, 8'd0, 1'b0, 64'd0, 8'd0);
		run_random(PHASE_ITEMS);

		program_regs(8'd255, 8'd255, 1'b1, {64{1'b1}}, 8'h80);
		run_random(PHASE_ITEMS);

		program_regs(8'd5, 8'd20, 1'b1, 64'h807F_0102_FEFD_0AF6, 8'h7F);
		run_random(PHASE_ITEMS);

		thr = 8'($urandom_range(0, 30));
		program_regs(thr, thr + 8'($urandom_range(0, 30)), 1'($urandom_range(0, 1)),
			small_offsets(), 8'($urandom_range(0, 16) - 8));
		run_random(PHASE_ITEMS);

		program_regs(8'd7, 8'd10, 1'b0, {$urandom, $urandom}, 8'($urandom));
		run_random(PHASE_ITEMS / 2);

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS battery_temp_rise_monitor_unit");
		else
			$display("FAIL battery_temp_rise_monitor_unit");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/btrm_pkg.sv
rtl/btrm_ctrl.sv
rtl/btrm_dp.sv
rtl/battery_temp_rise_monitor_unit.sv
dv/battery_temp_rise_monitor_checker.sv
dv/battery_temp_rise_monitor_unit_test.sv
